// ===== hdl/gpei_pkg.sv =====
// Types and constants for the GPIO port bank with edge interrupt unit.
// No dependencies; used by gpio_port_edge_interrupt_unit.
package gpei_pkg;

  localparam int unsigned NUM_LINES = 16;
  localparam int unsigned PIN_COUNT = 16;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_SAMPLE = 2'd2
  } cmd_t;

  localparam logic [3:0] REG_MODE     = 4'd0;
  localparam logic [3:0] REG_PULL     = 4'd1;
  localparam logic [3:0] REG_INPUT    = 4'd2;
  localparam logic [3:0] REG_OUTPUT   = 4'd3;
  localparam logic [3:0] REG_SETRESET = 4'd4;
  localparam logic [3:0] REG_AFLOW    = 4'd5;
  localparam logic [3:0] REG_AFHIGH   = 4'd6;
  localparam logic [3:0] REG_LINESRC0 = 4'd7;
  localparam logic [3:0] REG_LINESRC1 = 4'd8;
  localparam logic [3:0] REG_LINESRC2 = 4'd9;
  localparam logic [3:0] REG_LINESRC3 = 4'd10;
  localparam logic [3:0] REG_MASK     = 4'd11;
  localparam logic [3:0] REG_RISE     = 4'd12;
  localparam logic [3:0] REG_FALL     = 4'd13;
  localparam logic [3:0] REG_PENDING  = 4'd14;

  localparam logic [1:0] MODE_OUTPUT = 2'b01;

  // One bus access or pin sample beat, as held in the input register.
  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  port_index;
    logic [3:0]  reg_select;
    logic [31:0] write_data;
    logic [15:0] pin_levels;
  } item_t;

endpackage

// ===== hdl/gpio_port_edge_interrupt_unit.sv =====
// GPIO port bank with per-port pin registers and a 16-line edge interrupt unit.
// Depends on gpei_pkg (command codes, register selects, item type).
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-------------------------------------------
//   in      | in_valid  | in_stall  | command port_index reg_select write_data
//           |           |           | pin_levels
//   out     | out_valid | out_stall | read_data pad_out pad_drive irq_request
//           |           |           | bad_access
//
// A beat is registered on entry, processed from the input register and its result
// registered; one beat per cycle sustained while the result is not stalled.
// All state updates happen in the processing cycle, in arrival order.
// Synchronous reset clears every register bank and both stages' valid flags.
// A stalled result holds the processing stage; the input register then stalls
// only once it is itself occupied.
module gpio_port_edge_interrupt_unit #(
  parameter int unsigned NUM_PORTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [2:0]  port_index,
  input  logic [3:0]  reg_select,
  input  logic [31:0] write_data,
  input  logic [15:0] pin_levels,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic [15:0] pad_out,
  output logic [15:0] pad_drive,
  output logic [15:0] irq_request,
  output logic        bad_access
);

  localparam int unsigned IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  // port registers
  logic [31:0] pin_mode   [NUM_PORTS];
  logic [31:0] pin_pull   [NUM_PORTS];
  logic [15:0] out_latch  [NUM_PORTS];
  logic [15:0] in_sampled [NUM_PORTS];
  logic [31:0] alt_low    [NUM_PORTS];
  logic [31:0] alt_high   [NUM_PORTS];

  // interrupt unit
  logic [3:0]  line_source      [gpei_pkg::NUM_LINES];
  logic [3:0]  line_source_next [gpei_pkg::NUM_LINES];
  logic [15:0] line_mask, line_mask_next;
  logic [15:0] rise_enable, rise_enable_next;
  logic [15:0] fall_enable, fall_enable_next;
  logic [15:0] line_pending, line_pending_next;

  gpei_pkg::item_t item;
  logic            item_valid;
  logic            advance;

  logic             port_ok;
  logic [IDX_W-1:0] pidx;
  logic [1:0]       grp;
  logic [15:0]      lo_half, hi_half;

  logic [31:0] cur_mode, cur_pull, cur_afl, cur_afh;
  logic [15:0] cur_out, cur_in;
  logic [31:0] mode_val;
  logic [15:0] out_val;
  logic        mode_we, pull_we, out_we, in_we, afl_we, afh_we;
  logic [15:0] rising, falling, hit, src_match;

  logic [31:0] rd;
  logic        bad;
  logic [15:0] drive;

  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.command    <= command;
      item.port_index <= port_index;
      item.reg_select <= reg_select;
      item.write_data <= write_data;
      item.pin_levels <= pin_levels;
    end
  end

  assign port_ok = (32'(item.port_index) < NUM_PORTS);
  assign pidx    = IDX_W'(item.port_index);
  assign grp     = 2'(item.reg_select - gpei_pkg::REG_LINESRC0);
  assign lo_half = item.write_data[15:0];
  assign hi_half = item.write_data[31:16];

  // current registers of the addressed port, zero when there is no such port
  always_comb begin
    cur_mode = '0;
    cur_pull = '0;
    cur_out  = '0;
    cur_in   = '0;
    cur_afl  = '0;
    cur_afh  = '0;
    if (port_ok) begin
      cur_mode = pin_mode[pidx];
      cur_pull = pin_pull[pidx];
      cur_out  = out_latch[pidx];
      cur_in   = in_sampled[pidx];
      cur_afl  = alt_low[pidx];
      cur_afh  = alt_high[pidx];
    end
  end

  // edge detect for a sample beat
  always_comb begin
    rising  = ~cur_in & item.pin_levels;
    falling = cur_in & ~item.pin_levels;
    hit     = (rising & rise_enable) | (falling & fall_enable);
    for (int i = 0; i < gpei_pkg::NUM_LINES; i++) begin
      src_match[i] = (line_source[i] == {1'b0, item.port_index});
    end
  end

  always_comb begin
    mode_we           = 1'b0;
    pull_we           = 1'b0;
    out_we            = 1'b0;
    in_we             = 1'b0;
    afl_we            = 1'b0;
    afh_we            = 1'b0;
    mode_val          = cur_mode;
    out_val           = cur_out;
    line_source_next  = line_source;
    line_mask_next    = line_mask;
    rise_enable_next  = rise_enable;
    fall_enable_next  = fall_enable;
    line_pending_next = line_pending;
    rd                = '0;
    bad               = 1'b0;
    case (item.command)
      gpei_pkg::CMD_READ: begin
        case (item.reg_select)
          gpei_pkg::REG_MODE:    rd = cur_mode;
          gpei_pkg::REG_PULL:    rd = cur_pull;
          gpei_pkg::REG_INPUT:   rd = {16'h0000, cur_in};
          gpei_pkg::REG_OUTPUT:  rd = {16'h0000, cur_out};
          gpei_pkg::REG_AFLOW:   rd = cur_afl;
          gpei_pkg::REG_AFHIGH:  rd = cur_afh;
          gpei_pkg::REG_LINESRC0, gpei_pkg::REG_LINESRC1,
          gpei_pkg::REG_LINESRC2, gpei_pkg::REG_LINESRC3: begin
            for (int i = 0; i < 4; i++) begin
              rd[4*i +: 4] = line_source[{grp, 2'(i)}];
            end
          end
          gpei_pkg::REG_MASK:    rd = {16'h0000, line_mask};
          gpei_pkg::REG_RISE:    rd = {16'h0000, rise_enable};
          gpei_pkg::REG_FALL:    rd = {16'h0000, fall_enable};
          gpei_pkg::REG_PENDING: rd = {16'h0000, line_pending};
          default:               rd = '0;
        endcase
      end
      gpei_pkg::CMD_WRITE: begin
        case (item.reg_select)
          gpei_pkg::REG_MODE: begin
            mode_we = port_ok;
            if (port_ok) mode_val = item.write_data;
          end
          gpei_pkg::REG_PULL:  pull_we = port_ok;
          gpei_pkg::REG_INPUT: bad = 1'b1;
          gpei_pkg::REG_OUTPUT: begin
            out_we = port_ok;
            if (port_ok) out_val = lo_half;
          end
          gpei_pkg::REG_SETRESET: begin
            // set wins over clear on the same pin
            out_we = port_ok;
            if (port_ok) out_val = (cur_out & ~hi_half) | lo_half;
          end
          gpei_pkg::REG_AFLOW:  afl_we = port_ok;
          gpei_pkg::REG_AFHIGH: afh_we = port_ok;
          gpei_pkg::REG_LINESRC0, gpei_pkg::REG_LINESRC1,
          gpei_pkg::REG_LINESRC2, gpei_pkg::REG_LINESRC3: begin
            for (int i = 0; i < 4; i++) begin
              line_source_next[{grp, 2'(i)}] = item.write_data[4*i +: 4];
            end
          end
          gpei_pkg::REG_MASK:    line_mask_next    = lo_half;
          gpei_pkg::REG_RISE:    rise_enable_next  = lo_half;
          gpei_pkg::REG_FALL:    fall_enable_next  = lo_half;
          gpei_pkg::REG_PENDING: line_pending_next = line_pending & ~lo_half;
          default: ;
        endcase
      end
      gpei_pkg::CMD_SAMPLE: begin
        if (port_ok) begin
          in_we             = 1'b1;
          line_pending_next = line_pending | (hit & src_match);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < gpei_pkg::PIN_COUNT; i++) begin
      drive[i] = (mode_val[2*i +: 2] == gpei_pkg::MODE_OUTPUT);
    end
  end

  // state update in the processing cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        pin_mode[p]   <= '0;
        pin_pull[p]   <= '0;
        out_latch[p]  <= '0;
        in_sampled[p] <= '0;
        alt_low[p]    <= '0;
        alt_high[p]   <= '0;
      end
      for (int i = 0; i < gpei_pkg::NUM_LINES; i++) begin
        line_source[i] <= '0;
      end
      line_mask    <= '0;
      rise_enable  <= '0;
      fall_enable  <= '0;
      line_pending <= '0;
    end else if (advance) begin
      if (mode_we) pin_mode[pidx]   <= item.write_data;
      if (pull_we) pin_pull[pidx]   <= item.write_data;
      if (out_we)  out_latch[pidx]  <= out_val;
      if (in_we)   in_sampled[pidx] <= item.pin_levels;
      if (afl_we)  alt_low[pidx]    <= item.write_data;
      if (afh_we)  alt_high[pidx]   <= item.write_data;
      line_source  <= line_source_next;
      line_mask    <= line_mask_next;
      rise_enable  <= rise_enable_next;
      fall_enable  <= fall_enable_next;
      line_pending <= line_pending_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data   <= rd;
      pad_out     <= out_val;
      pad_drive   <= port_ok ? drive : 16'h0000;
      irq_request <= line_pending_next & line_mask_next;
      bad_access  <= bad;
    end
  end

endmodule
